>>> hw/rtl/rgb_to_hsv_converter_macros.svh
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent assertion forms for the converter.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// same-cycle implication
`define RHC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Stage types and the restoring divide step shared by the converter pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned NumW     = 11;
  localparam int unsigned SatRemW  = 16;
  localparam int unsigned HueRemW  = 19;
  localparam int unsigned DivSteps = 4;

  typedef struct packed {
    logic [ChW-1:0]  value;
    logic [ChW-1:0]  d;
    logic [NumW-1:0] num;
  } front_t;

  typedef struct packed {
    logic [ChW-1:0]     value;
    logic               sat_zero;
    logic               hue_zero;
    logic [SatRemW-1:0] sat_rem;
    logic [ChW-1:0]     sat_div;
    logic [ChW-1:0]     sat_quo;
    logic [HueRemW-1:0] hue_rem;
    logic [NumW-1:0]    hue_div;
    logic [ChW-1:0]     hue_quo;
  } div_t;

  typedef struct packed {
    logic [HueRemW-1:0] rem;
    logic [ChW-1:0]     quo;
  } divp_t;

  // Two restoring quotient bits, hi and hi-1.
  function automatic divp_t div_pair(input logic [HueRemW-1:0] rem,
                                     input logic [NumW-1:0]    dvs,
                                     input logic [ChW-1:0]     quo,
                                     input logic [2:0]         hi);
    divp_t              res;
    logic [2:0]         sh;
    logic [HueRemW-1:0] trial;
    res.rem = rem;
    res.quo = quo;
    for (int j = 0; j < 2; j++) begin
      sh    = hi - 3'(j);
      trial = HueRemW'(dvs) << sh;
      if (res.rem >= trial) begin
        res.rem     = res.rem - trial;
        res.quo[sh] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while hsv_stall is low; the six-stage pipeline
// has two divide bits per divider stage for saturation and hue.
// Bubbles collapse: a stage loads whenever it or the stage after it is free.
// Reset (synchronous, active high) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// 8-bit RGB to HSV pixel converter: max/min and sector, scaling, then two
// pipelined restoring dividers for saturation and hue.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  output logic                   pix_stall,
  input  logic [rhc_pkg::ChW-1:0] red,
  input  logic [rhc_pkg::ChW-1:0] green,
  input  logic [rhc_pkg::ChW-1:0] blue,
  output logic                   hsv_valid,
  input  logic                   hsv_stall,
  output logic [rhc_pkg::ChW-1:0] hue,
  output logic [rhc_pkg::ChW-1:0] saturation,
  output logic [rhc_pkg::ChW-1:0] value
);
  import rhc_pkg::*;

  localparam int unsigned Last = DivSteps + 1;

  logic [Last:0] vld;
  logic [Last:0] rdy;

  front_t         front;
  front_t         front_next;
  div_t           dv [1:Last];
  div_t           dv_next [1:Last];

  logic [ChW-1:0]  mx;
  logic [ChW-1:0]  mn;
  logic [NumW-1:0] d11;

  // Ready chain
  assign rdy[Last] = !vld[Last] || !hsv_stall;
  for (genvar i = 0; i < Last; i++) begin : g_rdy
    assign rdy[i] = !vld[i] || rdy[i+1];
  end
  assign pix_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pix_valid;
      end
      for (int i = 1; i <= Last; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: max, min, range and sector numerator
  always_comb begin
    mx = (red > green) ? red : green;
    mx = (mx > blue) ? mx : blue;
    mn = (red < green) ? red : green;
    mn = (mn < blue) ? mn : blue;
    front_next.value = mx;
    front_next.d     = mx - mn;
    d11              = {3'b000, front_next.d};
    if (mx == red) begin
      if (green < blue) begin
        front_next.num = (d11 << 2) + (d11 << 1) - {3'b000, 8'(blue - green)};
      end else begin
        front_next.num = {3'b000, 8'(green - blue)};
      end
    end else if (mx == green) begin
      front_next.num = (d11 << 1) + {3'b000, blue} - {3'b000, red};
    end else begin
      front_next.num = (d11 << 2) + {3'b000, red} - {3'b000, green};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      front <= front_next;
    end
  end

  // Stage 1: scale by 255 and form divisors
  always_comb begin
    dv_next[1].value    = front.value;
    dv_next[1].sat_zero = (front.value == '0);
    dv_next[1].hue_zero = (front.d == '0);
    dv_next[1].sat_rem  = {front.d, 8'h00} - {8'h00, front.d};
    dv_next[1].sat_div  = front.value;
    dv_next[1].sat_quo  = '0;
    dv_next[1].hue_rem  = {front.num, 8'h00} - {8'h00, front.num};
    dv_next[1].hue_div  = {1'b0, front.d, 2'b00} + {2'b00, front.d, 1'b0};
    dv_next[1].hue_quo  = '0;
  end

  // Stages 2..5: two quotient bits each
  for (genvar k = 2; k <= Last; k++) begin : g_div
    localparam logic [2:0] Hi = 3'(11 - 2 * k);
    divp_t sat_p;
    divp_t hue_p;
    always_comb begin
      sat_p = div_pair(HueRemW'(dv[k-1].sat_rem), NumW'(dv[k-1].sat_div),
                       dv[k-1].sat_quo, Hi);
      hue_p = div_pair(dv[k-1].hue_rem, dv[k-1].hue_div, dv[k-1].hue_quo, Hi);
      dv_next[k]         = dv[k-1];
      dv_next[k].sat_rem = SatRemW'(sat_p.rem);
      dv_next[k].sat_quo = sat_p.quo;
      dv_next[k].hue_rem = hue_p.rem;
      dv_next[k].hue_quo = hue_p.quo;
    end
  end

  for (genvar k = 1; k <= Last; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        dv[k] <= dv_next[k];
      end
    end
  end

  assign hsv_valid  = vld[Last];
  assign value      = dv[Last].value;
  assign saturation = dv[Last].sat_zero ? '0 : dv[Last].sat_quo;
  assign hue        = dv[Last].hue_zero ? '0 : dv[Last].hue_quo;

  `RHC_ASSERT_IMPLIES(a_gray_hue, hsv_valid && saturation == '0, hue == '0, "gray pixel with nonzero hue")
  `RHC_ASSERT_IMPLIES(a_black_sat, hsv_valid && value == '0, saturation == '0, "black pixel with nonzero saturation")
  `RHC_ASSERT_IMPLIES(a_hue_range, hsv_valid, hue != 8'hFF, "hue out of range")
  `RHC_ASSERT_NEXT(a_fill, vld[Last-1] && !vld[Last], hsv_valid, "result lost between stages")

endmodule
